FILE: rtl/ptc_pkg.sv
// ----------------------------------------------------------------------------
// ptc_pkg: shared definitions for the preorder tree checker
// Field widths, status codes, register indexes and sizing defaults.
// ----------------------------------------------------------------------------
package ptc_pkg;

	localparam int unsigned MAX_JOINTS_DEF = 1024;

	localparam int unsigned IDX_W   = 16;
	localparam int unsigned CNT_W   = 11;
	localparam int unsigned STAT_W  = 3;
	localparam int unsigned PDATA_W = 32;
	localparam int unsigned PADDR_W = 3;

	localparam logic [IDX_W-1:0] NO_PARENT   = 16'hFFFF;
	localparam logic [CNT_W-1:0] COUNTER_MAX = 11'd2047;
	localparam logic [CNT_W-1:0] TOTAL_RESET = 11'd1;

	// Register index, taken from paddr[2].
	localparam logic CFG_JOINT_TOTAL = 1'b0;

	typedef enum logic [STAT_W-1:0] {
		ST_OK           = 3'd0,
		ST_END_RANGE    = 3'd1,
		ST_WRONG_PARENT = 3'd2,
		ST_ESCAPES      = 3'd3,
		ST_TOO_MANY     = 3'd4
	} status_t;

endpackage

FILE: rtl/ptc_in_if.sv
// ----------------------------------------------------------------------------
// ptc_in_if: joint item channel
// Valid/ready channel carrying one joint of a skeleton in preorder.
// ----------------------------------------------------------------------------
interface ptc_in_if;
	logic        valid;
	logic        ready;
	logic        first_joint;
	logic [15:0] parent_index;
	logic [15:0] joint_end;

	modport source (output valid, output first_joint, output parent_index,
		output joint_end, input ready);
	modport sink (input valid, input first_joint, input parent_index,
		input joint_end, output ready);
endinterface

FILE: rtl/ptc_out_if.sv
// ----------------------------------------------------------------------------
// ptc_out_if: check result channel
// Valid/ready channel carrying the sticky status of one checked joint.
// ----------------------------------------------------------------------------
interface ptc_out_if;
	logic       valid;
	logic       ready;
	logic [2:0] check_status;
	logic       is_final;

	modport source (output valid, output check_status, output is_final, input ready);
	modport sink (input valid, input check_status, input is_final, output ready);
endinterface

FILE: rtl/preorder_tree_checker.sv
// ----------------------------------------------------------------------------
// preorder_tree_checker: preorder joint hierarchy checker
// Checks parent links and subtree ends of joints arriving in preorder.
// ----------------------------------------------------------------------------
// Channel   Dir  Handshake                 Payload
// in_ch     in   valid/ready               first_joint, parent_index, joint_end
// out_ch    out  valid/ready               check_status, is_final
// apb       in   psel/penable/pready       joint_total at byte address 0
//
// After acceptance an item is evaluated, then the walk reads the open subtree top
// from the stores and pops every closed subtree until one stays open; the parent
// check follows, with a fetch of the parent end when a walk cut short by its guard
// lacks it. An early failure or a recorded error skips the walk and goes straight
// to the result. A new item is taken only after the result of the last is taken.
// Reset clears the control state only. A waiting result blocks the input.
// ----------------------------------------------------------------------------
module preorder_tree_checker #(
	parameter int unsigned MAX_JOINTS = ptc_pkg::MAX_JOINTS_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	ptc_in_if.sink                      in_ch,
	ptc_out_if.source                   out_ch,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [ptc_pkg::PADDR_W-1:0] paddr,
	input  logic [ptc_pkg::PDATA_W-1:0] pwdata,
	output logic [ptc_pkg::PDATA_W-1:0] prdata,
	output logic                        pready
);
	import ptc_pkg::*;

	localparam int unsigned AW = (MAX_JOINTS > 1) ? $clog2(MAX_JOINTS) : 1;
	localparam int unsigned GW = $clog2(MAX_JOINTS + 1);
	localparam logic [IDX_W:0] MAXJ = (IDX_W+1)'(MAX_JOINTS);
	localparam logic [GW-1:0] GUARD_MAX = GW'(MAX_JOINTS);

	typedef enum logic [6:0] {
		S_IDLE = 7'b0000001,
		S_EVAL = 7'b0000010,
		S_WREQ = 7'b0000100,
		S_WCMP = 7'b0001000,
		S_PAR  = 7'b0010000,
		S_PCMP = 7'b0100000,
		S_OUT  = 7'b1000000
	} state_t;

	state_t              st_q;
	logic [CNT_W-1:0]    total_q;
	logic [CNT_W-1:0]    cnt_q;
	logic [CNT_W-1:0]    j_q;
	status_t             err_q;
	logic                final_q;
	logic [IDX_W-1:0]    open_top_q;
	logic [IDX_W-1:0]    top_q;
	logic [GW-1:0]       guard_q;
	logic                have_end_q;
	logic [IDX_W-1:0]    par_in_q;
	logic [IDX_W-1:0]    end_in_q;

	logic [IDX_W-1:0]    parent_mem [MAX_JOINTS];
	logic [IDX_W-1:0]    end_mem [MAX_JOINTS];
	logic [IDX_W-1:0]    par_rd_q;
	logic [IDX_W-1:0]    end_rd_q;

	logic                in_acc;
	logic                cfg_wr;
	logic                rd_en;
	logic                wr_en;
	logic [IDX_W-1:0]    j_ext;
	logic                j_beyond;
	logic                end_bad;
	logic                top_stop;
	logic                pop;

	assign in_acc = in_ch.valid && in_ch.ready;
	assign cfg_wr = psel && penable && pwrite && pready;
	assign pready = 1'b1;
	assign prdata = (paddr[2] == CFG_JOINT_TOTAL) ?
		{{(PDATA_W-CNT_W){1'b0}}, total_q} : '0;

	assign in_ch.ready         = (st_q == S_IDLE);
	assign out_ch.valid        = (st_q == S_OUT);
	assign out_ch.check_status = err_q;
	assign out_ch.is_final     = final_q;

	assign j_ext    = IDX_W'(j_q);
	assign j_beyond = (cnt_q >= total_q) || ({6'b0, cnt_q} >= MAXJ);
	assign end_bad  = (end_in_q <= IDX_W'(cnt_q)) || (end_in_q > IDX_W'(total_q));
	assign top_stop = (top_q == NO_PARENT) || ({1'b0, top_q} >= MAXJ) ||
		(guard_q >= GUARD_MAX);
	assign pop      = (end_rd_q <= j_ext);

	always_comb begin
		rd_en = 1'b0;
		wr_en = 1'b0;
		unique case (st_q)
			S_WREQ: rd_en = !top_stop;
			S_PAR: begin
				if (par_in_q == top_q && par_in_q != NO_PARENT &&
					{1'b0, par_in_q} < MAXJ && !have_end_q) begin
					rd_en = 1'b1;
				end
				if (par_in_q == top_q && par_in_q == NO_PARENT) begin
					wr_en = 1'b1;
				end
				if (par_in_q == top_q && par_in_q != NO_PARENT &&
					{1'b0, par_in_q} < MAXJ && have_end_q && end_in_q <= end_rd_q) begin
					wr_en = 1'b1;
				end
			end
			S_PCMP: wr_en = (end_in_q <= end_rd_q);
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			parent_mem[j_ext[AW-1:0]] <= par_in_q;
			end_mem[j_ext[AW-1:0]]    <= end_in_q;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			par_rd_q <= parent_mem[top_q[AW-1:0]];
			end_rd_q <= end_mem[top_q[AW-1:0]];
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			par_in_q <= in_ch.parent_index;
			end_in_q <= in_ch.joint_end;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q       <= S_IDLE;
			total_q    <= TOTAL_RESET;
			cnt_q      <= '0;
			j_q        <= '0;
			err_q      <= ST_OK;
			final_q    <= 1'b0;
			open_top_q <= NO_PARENT;
			top_q      <= NO_PARENT;
			guard_q    <= '0;
			have_end_q <= 1'b0;
		end else begin
			if (cfg_wr && paddr[2] == CFG_JOINT_TOTAL) begin
				total_q <= pwdata[CNT_W-1:0];
			end
			unique case (st_q)
				S_IDLE: begin
					if (in_acc) begin
						if (in_ch.first_joint) begin
							open_top_q <= NO_PARENT;
							cnt_q      <= '0;
							err_q      <= ST_OK;
						end
						st_q <= S_EVAL;
					end
				end
				S_EVAL: begin
					j_q        <= cnt_q;
					top_q      <= open_top_q;
					guard_q    <= '0;
					have_end_q <= 1'b0;
					if (cnt_q != COUNTER_MAX) begin
						cnt_q <= cnt_q + 1'b1;
					end
					if (j_beyond) begin
						final_q <= 1'b0;
						if (err_q == ST_OK) begin
							err_q <= ST_TOO_MANY;
						end
						st_q <= S_OUT;
					end else begin
						final_q <= ((CNT_W+1)'(cnt_q) + 1'b1) == (CNT_W+1)'(total_q);
						if (err_q != ST_OK) begin
							st_q <= S_OUT;
						end else if (end_bad) begin
							err_q <= ST_END_RANGE;
							st_q  <= S_OUT;
						end else begin
							st_q <= S_WREQ;
						end
					end
				end
				S_WREQ: begin
					if (top_stop) begin
						open_top_q <= top_q;
						st_q       <= S_PAR;
					end else begin
						st_q <= S_WCMP;
					end
				end
				S_WCMP: begin
					if (pop) begin
						top_q   <= par_rd_q;
						guard_q <= guard_q + 1'b1;
						st_q    <= S_WREQ;
					end else begin
						open_top_q <= top_q;
						have_end_q <= 1'b1;
						st_q       <= S_PAR;
					end
				end
				S_PAR: begin
					if (par_in_q != top_q) begin
						err_q <= ST_WRONG_PARENT;
						st_q  <= S_OUT;
					end else if (par_in_q == NO_PARENT) begin
						open_top_q <= j_ext;
						st_q       <= S_OUT;
					end else if ({1'b0, par_in_q} >= MAXJ) begin
						err_q <= ST_ESCAPES;
						st_q  <= S_OUT;
					end else if (!have_end_q) begin
						st_q <= S_PCMP;
					end else if (end_in_q > end_rd_q) begin
						err_q <= ST_ESCAPES;
						st_q  <= S_OUT;
					end else begin
						open_top_q <= j_ext;
						st_q       <= S_OUT;
					end
				end
				S_PCMP: begin
					if (end_in_q > end_rd_q) begin
						err_q <= ST_ESCAPES;
					end else begin
						open_top_q <= j_ext;
					end
					st_q <= S_OUT;
				end
				S_OUT: begin
					if (out_ch.ready) begin
						st_q <= S_IDLE;
					end
				end
				default: st_q <= S_IDLE;
			endcase
		end
	end

	a_one_side: assert property (@(posedge clk) disable iff (!arst_n)
		!(in_ch.ready && out_ch.valid))
		else $error("input taken while a result is pending");

	a_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		(err_q != ST_OK && !(in_acc && in_ch.first_joint)) |=> $stable(err_q))
		else $error("recorded status changed within a skeleton");

	a_wr_clean: assert property (@(posedge clk) disable iff (!arst_n)
		wr_en |-> (err_q == ST_OK && j_ext < IDX_W'(total_q)))
		else $error("store written for a failed or excess joint");

	a_cmp_after_req: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q == S_WCMP) |-> $past(st_q == S_WREQ && rd_en))
		else $error("walk compare without a store read");

	a_store_top: assert property (@(posedge clk) disable iff (!arst_n)
		wr_en |=> (open_top_q == $past(j_ext)))
		else $error("open subtree pointer not moved to the stored joint");

endmodule
